// ----- hdl/fpw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_pkg
// Shared types and constants for the four-level page walker.
// ----------------------------------------------------------------------------
package fpw_pkg;

  localparam int unsigned PaWidth    = 52;
  localparam int unsigned VaWidth    = 48;
  localparam int unsigned EntryWidth = 64;
  localparam int unsigned IdxWidth   = 9;

  // Entry bit positions
  localparam int unsigned PresentBit = 0;
  localparam int unsigned LargeBit   = 7;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_ENTRY = 1'b1
  } req_type_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } out_kind_e;

  typedef enum logic [1:0] {
    PAGE_4K = 2'd0,
    PAGE_2M = 2'd1,
    PAGE_1G = 2'd2
  } map_size_e;

  // Level whose entry is awaited, top table first
  typedef enum logic [1:0] {
    LVL_TOP  = 2'd0,
    LVL_DIR  = 2'd1,
    LVL_MID  = 2'd2,
    LVL_LEAF = 2'd3
  } walk_level_e;

  typedef struct packed {
    req_type_e               req_type;
    logic [PaWidth-1:0]      root_base;
    logic [VaWidth-1:0]      lin_addr;
    logic [EntryWidth-1:0]   entry_data;
  } walk_item_t;

  typedef struct packed {
    logic                    busy;
    walk_level_e             level;
    logic [VaWidth-1:0]      vaddr;
  } walk_state_t;

  typedef struct packed {
    out_kind_e               out_kind;
    logic [PaWidth-1:0]      read_address;
    logic [PaWidth-1:0]      phys_addr;
    logic                    fault;
    map_size_e               map_size;
  } walk_result_t;

  // 9-bit table index of a virtual address at a given level
  function automatic logic [IdxWidth-1:0] level_index(
    input logic [VaWidth-1:0] va,
    input walk_level_e        lvl
  );
    logic [IdxWidth-1:0] idx;
    unique case (lvl)
      LVL_TOP:  idx = va[47:39];
      LVL_DIR:  idx = va[38:30];
      LVL_MID:  idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

  // Byte offset of an 8-byte entry within its table, widened to PA width
  function automatic logic [PaWidth-1:0] entry_offset(input logic [IdxWidth-1:0] idx);
    return {{(PaWidth-IdxWidth-3){1'b0}}, idx, 3'b000};
  endfunction

  // Table frame carried in entry bits 12 to 35
  function automatic logic [PaWidth-1:0] entry_frame(input logic [EntryWidth-1:0] e);
    return {16'd0, e[35:12], 12'd0};
  endfunction

endpackage

// ----- hdl/fpw_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_step
// One walk step: next walk state and optional result for a single item.
// ----------------------------------------------------------------------------
module fpw_step import fpw_pkg::*; (
  input  walk_item_t   item_i,
  input  walk_state_t  state_i,
  output walk_state_t  state_o,
  output logic         emit_o,
  output walk_result_t result_o
);

  logic [PaWidth-1:0] frame;
  logic               present;
  logic               ps_flag;

  assign frame   = entry_frame(item_i.entry_data);
  assign present = item_i.entry_data[PresentBit];
  assign ps_flag = item_i.entry_data[LargeBit];

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '0;

    if (item_i.req_type == REQ_START) begin
      if (!state_i.busy) begin
        state_o.busy          = 1'b1;
        state_o.level         = LVL_TOP;
        state_o.vaddr         = item_i.lin_addr;
        emit_o                = 1'b1;
        result_o.out_kind     = KIND_READ;
        result_o.read_address = {item_i.root_base[PaWidth-1:4], 4'b0000}
                              + entry_offset(level_index(item_i.lin_addr, LVL_TOP));
      end
    end else if (state_i.busy) begin
      emit_o = 1'b1;
      unique case (state_i.level)
        LVL_TOP, LVL_DIR, LVL_MID: begin
          if (!present) begin
            state_o.busy      = 1'b0;
            state_o.level     = LVL_TOP;
            result_o.out_kind = KIND_DONE;
            result_o.fault    = 1'b1;
          end else if (ps_flag && state_i.level == LVL_DIR) begin
            // 1 GB page
            state_o.busy       = 1'b0;
            state_o.level      = LVL_TOP;
            result_o.out_kind  = KIND_DONE;
            result_o.phys_addr = {item_i.entry_data[51:30], state_i.vaddr[29:0]};
            result_o.map_size  = PAGE_1G;
          end else if (ps_flag && state_i.level == LVL_MID) begin
            // 2 MB page
            state_o.busy       = 1'b0;
            state_o.level      = LVL_TOP;
            result_o.out_kind  = KIND_DONE;
            result_o.phys_addr = frame + {31'd0, state_i.vaddr[20:0]};
            result_o.map_size  = PAGE_2M;
          end else begin
            state_o.level         = walk_level_e'(state_i.level + 2'd1);
            result_o.out_kind     = KIND_READ;
            result_o.read_address = frame
                                  + entry_offset(level_index(state_i.vaddr, state_o.level));
          end
        end
        default: begin
          state_o.busy      = 1'b0;
          state_o.level     = LVL_TOP;
          result_o.out_kind = KIND_DONE;
          if (item_i.entry_data[35:12] == 24'd0) begin
            result_o.fault = 1'b1;
          end else begin
            result_o.phys_addr = {16'd0, item_i.entry_data[35:12], state_i.vaddr[11:0]};
            result_o.map_size  = PAGE_4K;
          end
        end
      endcase
    end
  end

endmodule

// ----- hdl/four_level_page_walker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_walker_unit
// Four-level page table walker with registered input and result stages.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries start transactions (req_type 0, with table
//   base and virtual address) and entry transactions (req_type 1, with the
//   64-bit entry returned by memory). A transaction is taken on a rising
//   edge with in_valid_i high and in_stall_o low.
//   Each start taken while idle, and each entry taken while busy, yields one
//   result transaction: either an entry read request (out_kind 0) or the
//   finished translation (out_kind 1). Other transactions are dropped.
//   out_valid_o rises when the result stage, after the input register, is
//   free. One transaction is taken per cycle while out_stall_i does not hold
//   the result register: the whole step is a single pass of mask, add and
//   level update between the input register and the result register.
//   When out_stall_i holds the result register, the input register fills and
//   then in_stall_o rises; nothing is lost while both stages hold.
//   Reset empties both stages and returns the walker to idle at the top level.
// ----------------------------------------------------------------------------
module four_level_page_walker_unit import fpw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [PaWidth-1:0]    root_base_i,
  input  logic [VaWidth-1:0]    lin_addr_i,
  input  logic [EntryWidth-1:0] entry_data_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_kind_o,
  output logic [PaWidth-1:0]    read_address_o,
  output logic [PaWidth-1:0]    phys_addr_o,
  output logic                  fault_o,
  output logic [1:0]            map_size_o
);

  // Input stage
  logic         in_valid_q, in_valid_d;
  walk_item_t   in_item_q;
  logic         in_accept;

  // Walk state
  walk_state_t  state_q, state_d;

  // Result stage
  logic         out_valid_q, out_valid_d;
  walk_result_t out_q;

  // Step outputs
  walk_state_t  step_state;
  logic         step_emit;
  walk_result_t step_result;

  // Result register can take a new value this cycle
  logic         out_free;
  logic         advance;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign advance   = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept = in_valid_i && !in_stall_o;

  fpw_step u_step (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .state_o  (step_state),
    .emit_o   (step_emit),
    .result_o (step_result)
  );

  always_comb begin
    // Hold the input stage while stalled, drop it once it has advanced
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (out_free) begin
      in_valid_d = 1'b0;
    end

    // Advance the walk state only when the item leaves the input stage
    state_d = advance ? step_state : state_q;

    // A dropped item leaves the result stage empty
    out_valid_d = out_free ? (in_valid_q && step_emit) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{busy: 1'b0, level: LVL_TOP, vaddr: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= '{req_type:   req_type_e'(req_type_i),
                     root_base:  root_base_i,
                     lin_addr:   lin_addr_i,
                     entry_data: entry_data_i};
    end
    if (advance) begin
      out_q <= step_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_q.out_kind;
  assign read_address_o = out_q.read_address;
  assign phys_addr_o    = out_q.phys_addr;
  assign fault_o        = out_q.fault;
  assign map_size_o     = out_q.map_size;

endmodule
